// ===== rtl/sbusfr_pkg.sv =====
// shared constants and types for the sbus frame receiver
`timescale 1ns / 1ps

package sbusfr_pkg;

    localparam int FRAME_BYTES  = 25;
    localparam int NUM_CHANNELS = 12;
    localparam int STORE_DEPTH  = FRAME_BYTES - 1;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int POS_W        = $clog2(FRAME_BYTES + 1);
    localparam int CHAN_W       = 11;
    localparam int IDX_W        = 4;
    localparam int ACC_W        = CHAN_W + 7;
    localparam int CNT_W        = $clog2(ACC_W + 1);

    localparam logic [7:0]        START_BYTE   = 8'h0F;
    localparam logic [7:0]        END_BYTE     = 8'h00;
    localparam logic [ADDR_W-1:0] FLAG_ADDR    = ADDR_W'(23);
    localparam logic [ADDR_W-1:0] FIRST_ADDR   = ADDR_W'(1);
    localparam logic [POS_W-1:0]  LAST_POS     = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0]  STORE_LIMIT  = POS_W'(STORE_DEPTH);
    localparam logic [IDX_W-1:0]  LAST_CHANNEL = IDX_W'(NUM_CHANNELS - 1);
    localparam int                FL_BIT       = 2;
    localparam int                FS_BIT       = 3;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_FLAG_RD  = 5'b00010,
        ST_FLAG_CAP = 5'b00100,
        ST_RD       = 5'b01000,
        ST_ACC      = 5'b10000
    } state_t;

endpackage

// ===== rtl/sbusfr_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module sbusfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 24
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/sbus_frame_receiver_core.sv =====
// sbus frame receiver top level: frame tracking, byte store and channel unpacker
//
// Bytes are taken one per cycle while the block is collecting a frame. When the
// 25th byte of a frame is the end byte 0x00, the block drops s_tready and unpacks
// twelve 11-bit channels: it fetches the flag byte, captures it, then reads
// every payload byte (bytes 1 to 17) through the single read port of the frame
// store into a bit accumulator, and hands each channel word to the output
// register, where a word waits while m_tready is low. A frame with a wrong end
// byte produces no words and the block keeps accepting bytes. The last channel
// word may still wait in the output register while the next byte is accepted.
`timescale 1ns / 1ps

module sbus_frame_receiver_core
    import sbusfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // channel_value[10:0], lost_flag, failsafe, zero fill
    output logic [3:0]  m_tuser,   // channel_index[3:0]
    output logic        m_tlast    // last_channel
);

    state_t            state_reg, state_next;
    logic              in_frame_reg, in_frame_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  ch_reg, ch_next;
    logic              fl_reg, fl_next;
    logic              fs_reg, fs_next;

    logic              out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0] out_value_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic              out_fl_reg;
    logic              out_fs_reg;
    logic              out_last_reg;

    logic              in_accept;
    logic              out_free;
    logic              out_load;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic [ACC_W-1:0]  acc_sum;
    logic [CNT_W-1:0]  cnt_sum;

    sbusfr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    assign ram_raddr = (state_reg == ST_FLAG_RD) ? FLAG_ADDR : addr_reg;
    assign ram_waddr = in_frame_reg ? pos_reg[ADDR_W-1:0] : '0;
    assign ram_we    = in_accept && (in_frame_reg ? (pos_reg < STORE_LIMIT)
                                                  : (s_tdata == START_BYTE));

    assign acc_sum = acc_reg | (ACC_W'(ram_rdata) << cnt_reg);
    assign cnt_sum = cnt_reg + CNT_W'(8);

    always_comb begin
        state_next    = state_reg;
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        addr_next     = addr_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        ch_next       = ch_reg;
        fl_next       = fl_reg;
        fs_next       = fs_reg;
        out_load      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (!in_frame_reg) begin
                        if (s_tdata == START_BYTE) begin
                            in_frame_next = 1'b1;
                            pos_next      = POS_W'(1);
                        end
                    end else if (pos_reg == LAST_POS) begin
                        in_frame_next = 1'b0;
                        pos_next      = '0;
                        if (s_tdata == END_BYTE) begin
                            state_next = ST_FLAG_RD;
                        end
                    end else begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
            end
            ST_FLAG_RD: begin
                state_next = ST_FLAG_CAP;
            end
            ST_FLAG_CAP: begin
                fl_next    = ram_rdata[FL_BIT];
                fs_next    = ram_rdata[FS_BIT];
                addr_next  = FIRST_ADDR;
                acc_next   = '0;
                cnt_next   = '0;
                ch_next    = '0;
                state_next = ST_RD;
            end
            ST_RD: begin
                if (cnt_reg >= CNT_W'(CHAN_W)) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        acc_next = acc_reg >> CHAN_W;
                        cnt_next = cnt_reg - CNT_W'(CHAN_W);
                        ch_next  = ch_reg + IDX_W'(1);
                        if (ch_reg == LAST_CHANNEL) begin
                            state_next = ST_IDLE;
                        end
                    end
                end else begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                acc_next   = acc_sum;
                cnt_next   = cnt_sum;
                addr_next  = addr_reg + ADDR_W'(1);
                state_next = ST_RD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            in_frame_reg  <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            in_frame_reg  <= in_frame_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        acc_reg  <= acc_next;
        cnt_reg  <= cnt_next;
        ch_reg   <= ch_next;
        fl_reg   <= fl_next;
        fs_reg   <= fs_next;
        if (out_load) begin
            out_value_reg <= acc_reg[CHAN_W-1:0];
            out_index_reg <= ch_reg;
            out_fl_reg    <= fl_reg;
            out_fs_reg    <= fs_reg;
            out_last_reg  <= (ch_reg == LAST_CHANNEL);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_fs_reg, out_fl_reg, out_value_reg};
    assign m_tuser  = out_index_reg;
    assign m_tlast  = out_last_reg;

endmodule
